### rtl/dpts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpts_pkg
// shared types, constants and the score function of the task scheduler
// ----------------------------------------------------------------------------
package dpts_pkg;

    localparam int QueueDepthDef = 64;
    localparam logic [15:0] HighBonusRst = 16'd7000;
    localparam logic [15:0] LowBonusRst  = 16'd3000;
    localparam logic signed [31:0] ScoreMin = -32'sd2147483647;

    localparam logic [2:0] CmdTimer  = 3'd0;
    localparam logic [2:0] CmdArrive = 3'd1;
    localparam logic [2:0] CmdFinish = 3'd2;
    localparam logic [2:0] CmdIoReq  = 3'd3;
    localparam logic [2:0] CmdIoEnd  = 3'd4;

    localparam logic RegHighBonus = 1'b0;
    localparam logic RegLowBonus  = 1'b1;

    // full ready record (blocked queue uses id and score only)
    typedef struct packed {
        logic signed [31:0] score;
        logic [15:0]        id;
        logic [30:0]        deadline;
        logic [30:0]        arrival;
        logic [1:0]         cls;
    } t_rec;

    // chain command broadcast to every cell
    typedef struct packed {
        logic push;   // append record at position count
        logic pop;    // remove first best entry, shift the tail down
    } t_chain_op;

    // score of a task at time t, clamped; bonus already selected by class
    function automatic logic signed [31:0] score_of(
        input logic [30:0] dl, input logic [30:0] ar,
        input logic [15:0] bonus, input logic [30:0] t);
        logic signed [33:0] rest;
        logic signed [33:0] el;
        logic signed [35:0] num;
        logic signed [35:0] q;
        begin
            rest = $signed({3'b000, dl}) - $signed({3'b000, t});
            el   = $signed({3'b000, t}) - $signed({3'b000, ar});
            num  = ($signed({{20{1'b0}}, bonus}) - 36'(rest)) * 36'sd2 - 36'(el);
            q    = num >>> 1;
            if (num[35] && num[0]) q = q + 36'sd1;
            if (rest <= 34'sd0) score_of = ScoreMin;
            else if (q < 36'(ScoreMin)) score_of = ScoreMin;
            else if (q > 36'sd2147483647) score_of = 32'sd2147483647;
            else score_of = q[31:0];
        end
    endfunction

endpackage
`default_nettype wire

### rtl/dpts_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpts_cell
// one slot of the queue chain: holds a record, loads on push, shifts on pop
// ----------------------------------------------------------------------------
module dpts_cell (
    input  wire logic          i_clk,
    input  wire dpts_pkg::t_chain_op i_op,
    input  wire logic          i_here,      // push lands in this slot
    input  wire logic          i_shift,     // slot at or after the removed one
    input  wire dpts_pkg::t_rec i_new,
    input  wire dpts_pkg::t_rec i_next,     // record of the upper neighbor
    output dpts_pkg::t_rec     o_rec
);
    import dpts_pkg::*;

    t_rec r_rec;

    always_ff @(posedge i_clk) begin
        if (i_op.pop && i_shift) begin
            r_rec <= i_next;
        end else if (i_op.push && i_here) begin
            r_rec <= i_new;
        end
    end

    assign o_rec = r_rec;
endmodule
`default_nettype wire

### rtl/dpts_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpts_queue
// chain of cells with a count and a serial best-entry search
// ----------------------------------------------------------------------------
module dpts_queue #(
    parameter int Depth = dpts_pkg::QueueDepthDef
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire logic           i_pop,
    input  wire logic           i_scan,     // start best search
    input  wire dpts_pkg::t_rec i_new,
    output logic                o_scan_done,
    output dpts_pkg::t_rec      o_best,
    output logic [$clog2(Depth+1)-1:0] o_count
);
    import dpts_pkg::*;

    localparam int IW = $clog2(Depth);
    localparam int CW = $clog2(Depth+1);

    t_rec      w_rec [Depth];
    t_chain_op w_op;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_best_idx;
    logic [IW-1:0] r_scan_idx;
    logic          r_scanning;
    t_rec          r_best;

    assign w_op.push = i_push && (r_count < CW'(Depth));
    assign w_op.pop  = i_pop;

    for (genvar g = 0; g < Depth; g++) begin : g_cell
        t_rec w_next;
        if (g == Depth - 1) begin : g_last
            assign w_next = w_rec[g];
        end else begin : g_mid
            assign w_next = w_rec[g+1];
        end
        dpts_cell u_cell (
            .i_clk  (i_clk),
            .i_op   (w_op),
            .i_here (r_count == CW'(g)),
            .i_shift(IW'(g) >= r_best_idx),
            .i_new  (i_new),
            .i_next (w_next),
            .o_rec  (w_rec[g])
        );
    end

    // serial search, one cell a cycle; first highest wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_scanning <= 1'b0;
            r_scan_idx <= '0;
            r_best_idx <= '0;
        end else begin
            if (w_op.pop) begin
                r_count <= r_count - CW'(1);
            end else if (w_op.push) begin
                r_count <= r_count + CW'(1);
            end
            if (i_scan) begin
                r_scanning <= (r_count > CW'(1));
                r_scan_idx <= IW'(1);
                r_best_idx <= '0;
                r_best     <= w_rec[0];
            end else if (r_scanning) begin
                if (w_rec[r_scan_idx].score > r_best.score) begin
                    r_best     <= w_rec[r_scan_idx];
                    r_best_idx <= r_scan_idx;
                end
                if (CW'(r_scan_idx) + CW'(1) >= r_count) r_scanning <= 1'b0;
                r_scan_idx <= r_scan_idx + IW'(1);
            end
        end
    end

    assign o_scan_done = !r_scanning;
    assign o_best  = r_best;
    assign o_count = r_count;
endmodule
`default_nettype wire

### rtl/deadline_priority_task_scheduler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_priority_task_scheduler_unit
// event-driven cpu and io task scheduler with score-ordered queues
// ----------------------------------------------------------------------------
// One event beat on s_axis gives one result beat on m_axis with the cpu and
// io owners and the overflow flags. Configuration writes set the class
// bonuses, index 0 the high one and index 1 the low one; the user is to
// make them only while idle, the block itself does not enforce this.
// An event is handled by a sequencer: score, optional push, then a search of
// both queue chains one cell per cycle, then the pop and the late push.
// The result waits on the serial walk over the cells of the fuller queue.
// s_axis_tready comes back in the same cycle as the result is loaded, so a
// new event is taken only after the result of the last one is loaded.
// One event is in flight at a time.
// The result waits in an output register; a stalled receiver holds the
// sequencer in its last step, with s_axis_tready low, until the waiting beat
// is taken.
// Reset empties both queues, clears the running record and owners, and
// restores the bonus registers to 7000 and 3000.
// ----------------------------------------------------------------------------
module deadline_priority_task_scheduler_unit #(
    parameter int QUEUE_DEPTH = dpts_pkg::QueueDepthDef
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // command[2:0] first_of_batch[3] batch_cpu[19:4] batch_io[35:20]
    // event_time[66:36] task_id[82:67] task_deadline[113:83]
    // task_arrival[144:114] task_class[146:145], zero fill to 152
    input  wire logic [151:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // cpu_task[15:0] io_task[31:16] ready_overflow[32] blocked_overflow[33]
    output logic [39:0]       m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [0:0]   i_cfg_idx,
    input  wire logic [15:0]  i_cfg_data
);
    import dpts_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH+1);
    localparam logic [3:0] StIdle = 4'd0, StPush = 4'd1, StScan = 4'd2,
        StWait = 4'd3, StDecide = 4'd4, StPush2 = 4'd5, StOut = 4'd6;

    logic [3:0] r_st;
    logic [15:0] r_hb, r_lb;
    logic [151:0] r_in;
    logic [15:0] r_wcpu, r_wio;
    t_rec r_run;
    t_rec r_prev;
    logic r_rov, r_bov;
    logic [39:0] r_out;
    logic r_ovalid;
    logic signed [31:0] r_s;

    wire [2:0]  w_cmd = r_in[2:0];
    wire [15:0] w_ccpu = r_in[19:4];
    wire [30:0] w_t   = r_in[66:36];
    t_rec w_task;
    assign w_task.id = r_in[82:67];
    assign w_task.deadline = r_in[113:83];
    assign w_task.arrival = r_in[144:114];
    assign w_task.cls = r_in[146:145];
    assign w_task.score = r_s;

    function automatic logic [15:0] bonus_of(input logic [1:0] c,
        input logic [15:0] hb, input logic [15:0] lb);
        bonus_of = (c == 2'd2) ? hb : (c == 2'd1) ? lb : 16'd0;
    endfunction

    // queue controls
    logic rq_push, rq_pop, rq_scan, bq_push, bq_pop, bq_scan;
    t_rec rq_new, bq_new, rq_best, bq_best;
    logic rq_done, bq_done;
    logic [CW-1:0] rq_cnt, bq_cnt;
    logic r_rq_full_tmr;

    dpts_queue #(.Depth(QUEUE_DEPTH)) u_ready (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(rq_push), .i_pop(rq_pop),
        .i_scan(rq_scan), .i_new(rq_new), .o_scan_done(rq_done),
        .o_best(rq_best), .o_count(rq_cnt));
    dpts_queue #(.Depth(QUEUE_DEPTH)) u_blocked (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(bq_push), .i_pop(bq_pop),
        .i_scan(bq_scan), .i_new(bq_new), .o_scan_done(bq_done),
        .o_best(bq_best), .o_count(bq_cnt));

    wire w_rfull = (rq_cnt == CW'(QUEUE_DEPTH));
    wire w_bfull = (bq_cnt == CW'(QUEUE_DEPTH));
    wire w_timer_push = (w_cmd == CmdTimer) && (w_ccpu != 16'd0);
    wire w_cpu_pop = (w_cmd == CmdFinish || w_cmd == CmdIoReq) && r_wcpu == 16'd0
        && rq_cnt != '0;
    wire w_io_pop = (w_cmd == CmdIoEnd) && r_wio == 16'd0 && bq_cnt != '0;

    always_comb begin
        rq_push = 1'b0; rq_pop = 1'b0; rq_scan = 1'b0;
        bq_push = 1'b0; bq_pop = 1'b0; bq_scan = 1'b0;
        rq_new = w_task; bq_new = w_task;
        case (r_st)
            StPush: begin
                if (w_timer_push) begin
                    rq_new = r_run; rq_new.score = r_s;
                    rq_push = !w_rfull;
                end else if (w_cmd == CmdArrive && w_ccpu != 16'd0) begin
                    rq_push = 1'b1;
                end
            end
            StScan: begin
                rq_scan = 1'b1; bq_scan = 1'b1;
            end
            StDecide: begin
                if (w_timer_push) begin
                    rq_pop = !(r_rq_full_tmr && (r_s > rq_best.score));
                end else begin
                    rq_pop = w_cpu_pop;
                    bq_pop = w_io_pop;
                end
            end
            StPush2: begin
                if (w_timer_push) begin
                    // old running record goes behind the entries left in the queue
                    rq_new = r_prev; rq_new.score = r_s;
                    rq_push = r_rq_full_tmr;
                end else if (w_cmd == CmdIoReq && r_wio != 16'd0) begin
                    bq_push = 1'b1;
                end else if (w_cmd == CmdIoEnd && r_wcpu != 16'd0) begin
                    rq_push = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_st == StIdle);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle; r_hb <= HighBonusRst; r_lb <= LowBonusRst;
            r_wcpu <= '0; r_wio <= '0; r_run <= '0; r_ovalid <= 1'b0;
            r_rov <= 1'b0; r_bov <= 1'b0; r_rq_full_tmr <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == RegHighBonus) r_hb <= i_cfg_data;
                else r_lb <= i_cfg_data;
            end
            if (r_ovalid && m_axis_tready && r_st != StOut) r_ovalid <= 1'b0;
            case (r_st)
                StIdle: if (s_axis_tvalid) begin
                    r_in <= s_axis_tdata;
                    if (s_axis_tdata[3]) begin
                        r_wcpu <= s_axis_tdata[19:4];
                        r_wio  <= s_axis_tdata[35:20];
                    end
                    r_rov <= 1'b0; r_bov <= 1'b0;
                    r_st <= StPush;
                    if (s_axis_tdata[2:0] == CmdTimer)
                        r_s <= score_of(r_run.deadline, r_run.arrival,
                            bonus_of(r_run.cls, r_hb, r_lb), s_axis_tdata[66:36]);
                    else
                        r_s <= score_of(s_axis_tdata[113:83], s_axis_tdata[144:114],
                            bonus_of(s_axis_tdata[146:145], r_hb, r_lb),
                            s_axis_tdata[66:36]);
                end
                StPush: begin
                    r_rq_full_tmr <= w_rfull;
                    if (w_cmd == CmdArrive) begin
                        if (w_ccpu == 16'd0) begin
                            r_wcpu <= w_task.id; r_run <= w_task;
                        end else r_rov <= w_rfull;
                    end
                    r_st <= StScan;
                end
                StScan: r_st <= StWait;
                StWait: if (rq_done && bq_done) r_st <= StDecide;
                StDecide: begin
                    r_prev <= r_run;
                    if (rq_pop) begin
                        r_run <= rq_best; r_wcpu <= rq_best.id;
                    end else if (w_timer_push) begin
                        r_wcpu <= r_run.id;
                    end
                    if (bq_pop) r_wio <= bq_best.id;
                    r_st <= StPush2;
                end
                StPush2: begin
                    if (w_cmd == CmdIoReq) begin
                        if (r_wio == 16'd0) r_wio <= w_task.id;
                        else r_bov <= w_bfull;
                    end else if (w_cmd == CmdIoEnd) begin
                        if (r_wcpu == 16'd0) begin
                            r_wcpu <= w_task.id; r_run <= w_task;
                        end else r_rov <= w_rfull;
                    end
                    r_st <= StOut;
                end
                StOut: if (!r_ovalid || m_axis_tready) begin
                    r_out <= {6'd0, r_bov, r_rov, r_wio, r_wcpu};
                    r_ovalid <= 1'b1;
                    r_st <= StIdle;
                end
                default: r_st <= StIdle;
            endcase
        end
    end

    // one event in flight: no input while the sequencer is busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != StIdle) |-> !s_axis_tready) else $error("ready while busy");
    // a queue never grows past its depth
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rq_cnt <= CW'(QUEUE_DEPTH) && bq_cnt <= CW'(QUEUE_DEPTH))
        else $error("queue count overrun");
    // a result appears only after the sequencer has finished an event
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_st) == StOut) else $error("stray result");
endmodule
`default_nettype wire
